### hdl/lfsa_pkg.sv
package lfsa_pkg;

  localparam int CAPACITY  = 2048;
  localparam int IDX_W     = 11;
  localparam int CFG_W     = 12;
  localparam int STAT_W    = 2;
  localparam int CFG_RESET = 2048;

  // heap entries and bump pointer both count up to CAPACITY
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = $clog2(CAPACITY + 1);
  localparam int OFS_W  = LEVELS - 1;
  localparam int LVL_W  = (LEVELS > 2) ? $clog2(LEVELS) : 1;
  localparam int CMP_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    TOK_INSERT = 2'd0,
    TOK_FETCH  = 2'd1,
    TOK_SIFT   = 2'd2,
    TOK_DONE   = 2'd3
  } tok_kind_t;

  // travels down the chain, one level per cell
  typedef struct packed {
    logic             valid;
    tok_kind_t        kind;
    logic [IDX_W-1:0] value;
    logic [IDX_W-1:0] root;
    logic [CNT_W-1:0] path;
    logic [LVL_W-1:0] depth;
    logic [OFS_W-1:0] ofs;
    logic [CNT_W-1:0] count;
  } token_t;

  // write into the level above, from a sift step
  typedef struct packed {
    logic             we;
    logic [OFS_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } wb_t;

  typedef struct packed {
    logic             we;
    logic [OFS_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [OFS_W-1:0] raddr_a;
    logic [OFS_W-1:0] raddr_b;
  } ram_req_t;

  function automatic logic [LVL_W-1:0] msb_pos(input logic [CNT_W-1:0] v);
    logic [LVL_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) pos = LVL_W'(i);
    end
    return pos;
  endfunction

endpackage

### hdl/lfsa_ram.sv
module lfsa_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 11,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/lfsa_cell.sv
module lfsa_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lfsa_pkg::LVL_W-1:0]        level,
  input  lfsa_pkg::token_t                  tok_in,
  output lfsa_pkg::token_t                  tok_out,
  input  lfsa_pkg::wb_t                     wb_in,
  output lfsa_pkg::wb_t                     wb_out,
  output lfsa_pkg::ram_req_t                ram_req,
  input  logic [lfsa_pkg::IDX_W-1:0]        rdata_a,
  input  logic [lfsa_pkg::IDX_W-1:0]        rdata_b
);

  import lfsa_pkg::*;

  logic             busy, busy_next;
  token_t           hold, cur, tok_nxt;
  wb_t              wb_nxt;
  logic             own_we, need_read, lvl_lt, lvl_eq;
  logic [LVL_W-1:0] sh;
  logic [CNT_W-1:0] anc, anc_x, lvl_bit;
  logic [OFS_W-1:0] path_ofs, c0_ofs, c1_ofs;
  logic [OFS_W:0]   c_dbl;
  logic [CNT_W:0]   g0, g1;
  logic             ex0, ex1, pick1, take;
  logic [IDX_W-1:0] cmin;

  assign cur = busy ? hold : tok_in;

  // offset at this level of the ancestor of the target slot
  always_comb begin
    lvl_lt   = level < cur.depth;
    lvl_eq   = level == cur.depth;
    sh       = cur.depth - level;
    anc      = cur.path >> sh;
    lvl_bit  = CNT_W'(1) << level;
    anc_x    = anc ^ lvl_bit;
    path_ofs = anc_x[OFS_W-1:0];
  end

  // children of the parent slot that a sift step carries in
  always_comb begin
    c_dbl  = {cur.ofs, 1'b0};
    c0_ofs = c_dbl[OFS_W-1:0];
    c1_ofs = c0_ofs | OFS_W'(1);
    g0     = {1'b0, lvl_bit} - (CNT_W+1)'(1) + {1'b0, c_dbl};
    g1     = g0 + (CNT_W+1)'(1);
    ex0    = g0 < {1'b0, cur.count};
    ex1    = g1 < {1'b0, cur.count};
    pick1  = ex1 && (rdata_b < rdata_a);
    cmin   = pick1 ? rdata_b : rdata_a;
    take   = ex0 && (cmin < cur.value);
  end

  always_comb begin
    unique case (cur.kind)
      TOK_INSERT: need_read = lvl_lt;
      TOK_FETCH:  need_read = (level == '0) || lvl_eq;
      TOK_SIFT:   need_read = level != '0;
      TOK_DONE:   need_read = 1'b0;
    endcase
  end

  always_comb begin
    busy_next     = busy;
    tok_nxt       = cur;
    tok_nxt.valid = 1'b0;
    wb_nxt        = '0;
    own_we        = 1'b0;
    if (!busy && tok_in.valid) begin
      if (need_read) begin
        busy_next = 1'b1;
      end else begin
        tok_nxt.valid = 1'b1;
        if (cur.kind == TOK_INSERT && lvl_eq) begin
          own_we       = 1'b1;
          tok_nxt.kind = TOK_DONE;
        end
      end
    end else if (busy) begin
      busy_next     = 1'b0;
      tok_nxt.valid = 1'b1;
      unique case (cur.kind)
        TOK_INSERT: begin
          // smaller value stays on the path, larger one moves on
          if (cur.value < rdata_a) begin
            own_we        = 1'b1;
            tok_nxt.value = rdata_a;
          end
        end
        TOK_FETCH: begin
          if (level == '0) tok_nxt.root = rdata_a;
          if (lvl_eq) tok_nxt.value = rdata_b;
        end
        TOK_SIFT: begin
          wb_nxt.we   = 1'b1;
          wb_nxt.addr = cur.ofs;
          if (take) begin
            wb_nxt.data = cmin;
            tok_nxt.ofs = pick1 ? c1_ofs : c0_ofs;
          end else begin
            wb_nxt.data  = cur.value;
            tok_nxt.kind = TOK_DONE;
          end
        end
        TOK_DONE: begin
        end
      endcase
    end
  end

  always_comb begin
    ram_req.we      = own_we | wb_in.we;
    ram_req.waddr   = own_we ? path_ofs : wb_in.addr;
    ram_req.wdata   = own_we ? cur.value : wb_in.data;
    ram_req.raddr_a = (cur.kind == TOK_SIFT)  ? c0_ofs :
                      (cur.kind == TOK_FETCH) ? '0 : path_ofs;
    ram_req.raddr_b = (cur.kind == TOK_SIFT)  ? c1_ofs : path_ofs;
  end

  always_ff @(posedge clk) begin
    if (!busy && tok_in.valid) hold <= tok_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      tok_out.valid <= 1'b0;
      wb_out.we     <= 1'b0;
    end else begin
      busy    <= busy_next;
      tok_out <= tok_nxt;
      wb_out  <= wb_nxt;
    end
  end

endmodule

### hdl/lowest_first_slot_allocator_core.sv
// Slot allocator: an allocate returns the lowest freed slot held in a min-heap, else the next
// slot from a bump pointer, else reports full; a free steps the bump pointer back or pushes
// the slot onto the heap. One item is worked on at a time. Items that touch only the bump
// pointer, and bad or full ones, give their result from the S_DONE state once the output
// register is free. The heap is a chain of one cell per heap level (LEVELS = 12 for 2048
// slots), each with its own level RAM whose read data is registered: a token passes a cell
// through its output register, and a cell that reads holds the token until its read is done.
// A free into the heap runs an insert pass down the chain, whose path ends at the new entry's level.
// An allocate from the heap fetches root and last entry in one pass, reading at the root and
// at the last entry's level, then sifts down, reading at each level the moved entry reaches,
// unless the heap held a single entry. The next item can be taken in the cycle after the
// result is loaded. A new item is taken while the previous result still waits on rsp_stall.
module lowest_first_slot_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lfsa_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          operation,
  input  logic [lfsa_pkg::IDX_W-1:0]    free_index,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [lfsa_pkg::IDX_W-1:0]    granted_index,
  output logic [lfsa_pkg::STAT_W-1:0]   status
);

  import lfsa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FETCH  = 5'b00010,
    S_SIFT   = 5'b00100,
    S_INSERT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [CFG_W-1:0] slots_in_use;
  logic [CNT_W-1:0] bump_ptr, bump_ptr_next;
  logic [CNT_W-1:0] heap_count, heap_count_next;
  token_t           launch, launch_next;
  logic [IDX_W-1:0] res_granted, res_granted_next;
  stat_t            res_status, res_status_next;
  logic             req_take, rsp_load;
  logic             bump_ok, idx_bad, idx_top, heap_full;

  token_t           chain [LEVELS+1];
  wb_t              wbs   [LEVELS+1];
  ram_req_t         rq    [LEVELS];
  logic [IDX_W-1:0] rd_a  [LEVELS];
  logic [IDX_W-1:0] rd_b  [LEVELS];

  assign req_stall = state != S_IDLE;
  assign req_take  = req_valid && !req_stall;
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) slots_in_use <= CFG_W'(CFG_RESET);
    else if (cfg_write) slots_in_use <= cfg_data;
  end

  always_comb begin
    bump_ok   = (CMP_W'(bump_ptr) < CMP_W'(slots_in_use)) &&
                (CMP_W'(bump_ptr) < CMP_W'(CAPACITY));
    idx_bad   = CMP_W'(free_index) >= CMP_W'(bump_ptr);
    idx_top   = (CMP_W'(free_index) + CMP_W'(1)) == CMP_W'(bump_ptr);
    heap_full = CMP_W'(heap_count) >= CMP_W'(CAPACITY);
  end

  always_comb begin
    state_next       = state;
    bump_ptr_next    = bump_ptr;
    heap_count_next  = heap_count;
    launch_next      = '0;
    res_granted_next = res_granted;
    res_status_next  = res_status;
    unique case (state)
      S_IDLE: begin
        if (req_take) begin
          res_granted_next = '0;
          res_status_next  = STAT_DONE;
          state_next       = S_DONE;
          if (operation == OP_ALLOC) begin
            if (heap_count != '0) begin
              // pick up root and last entry in one pass down the chain
              heap_count_next   = heap_count - CNT_W'(1);
              launch_next.valid = 1'b1;
              launch_next.kind  = TOK_FETCH;
              launch_next.path  = heap_count;
              launch_next.depth = msb_pos(heap_count);
              state_next        = S_FETCH;
            end else if (bump_ok) begin
              res_granted_next = bump_ptr[IDX_W-1:0];
              bump_ptr_next    = bump_ptr + CNT_W'(1);
            end else begin
              res_status_next = STAT_FULL;
            end
          end else begin
            if (idx_bad) begin
              res_status_next = STAT_BAD;
            end else if (idx_top) begin
              bump_ptr_next = bump_ptr - CNT_W'(1);
            end else if (heap_full) begin
              res_status_next = STAT_BAD;
            end else begin
              heap_count_next   = heap_count + CNT_W'(1);
              launch_next.valid = 1'b1;
              launch_next.kind  = TOK_INSERT;
              launch_next.value = free_index;
              launch_next.path  = heap_count + CNT_W'(1);
              launch_next.depth = msb_pos(heap_count + CNT_W'(1));
              state_next        = S_INSERT;
            end
          end
        end
      end
      S_FETCH: begin
        if (chain[LEVELS].valid) begin
          res_granted_next = chain[LEVELS].root;
          if (heap_count == '0) begin
            state_next = S_DONE;
          end else begin
            launch_next.valid = 1'b1;
            launch_next.kind  = TOK_SIFT;
            launch_next.value = chain[LEVELS].value;
            launch_next.ofs   = '0;
            launch_next.count = heap_count;
            state_next        = S_SIFT;
          end
        end
      end
      S_SIFT, S_INSERT: begin
        if (chain[LEVELS].valid) state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bump_ptr     <= '0;
      heap_count   <= '0;
      launch.valid <= 1'b0;
    end else begin
      state      <= state_next;
      bump_ptr   <= bump_ptr_next;
      heap_count <= heap_count_next;
      launch     <= launch_next;
    end
  end

  always_ff @(posedge clk) begin
    res_granted <= res_granted_next;
    res_status  <= res_status_next;
    if (rsp_load) begin
      granted_index <= res_granted;
      status        <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (rsp_load) rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  assign chain[0]    = launch;
  assign wbs[LEVELS] = '0;

  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    localparam int FULL = 1 << k;
    localparam int DEP  = ((CAPACITY - (FULL - 1)) < FULL) ? (CAPACITY - (FULL - 1)) : FULL;
    localparam int AW   = (DEP > 1) ? $clog2(DEP) : 1;

    lfsa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .level   (LVL_W'(k)),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1]),
      .wb_in   (wbs[k+1]),
      .wb_out  (wbs[k]),
      .ram_req (rq[k]),
      .rdata_a (rd_a[k]),
      .rdata_b (rd_b[k])
    );

    lfsa_ram #(
      .DEPTH (DEP),
      .WIDTH (IDX_W)
    ) u_ram (
      .clk     (clk),
      .we      (rq[k].we),
      .waddr   (rq[k].waddr[AW-1:0]),
      .wdata   (rq[k].wdata),
      .raddr_a (rq[k].raddr_a[AW-1:0]),
      .raddr_b (rq[k].raddr_b[AW-1:0]),
      .rdata_a (rd_a[k]),
      .rdata_b (rd_b[k])
    );
  end

`ifndef NO_ASSERTIONS
  a_tail_when_waiting: assert property (@(posedge clk) disable iff (rst)
    chain[LEVELS].valid |-> (state == S_FETCH || state == S_SIFT || state == S_INSERT))
    else $error("token left the chain while no heap operation was running");

  a_fetch_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH && chain[LEVELS].valid) |-> chain[LEVELS].kind == TOK_FETCH)
    else $error("fetch pass returned the wrong kind of token");

  a_sift_nonempty: assert property (@(posedge clk) disable iff (rst)
    (launch.valid && launch.kind == TOK_SIFT) |-> heap_count != '0)
    else $error("sift launched on an empty heap");

  a_no_write_above_root: assert property (@(posedge clk) disable iff (rst)
    !wbs[0].we)
    else $error("sift wrote above the root level");

  a_zero_grant_on_error: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != STAT_DONE) |-> granted_index == '0)
    else $error("non-zero slot reported with a full or bad status");
`endif

endmodule

### tb/sv/lowest_first_slot_allocator_core_tb.sv
`timescale 1ns / 100ps

module lowest_first_slot_allocator_core_tb;
  import lfsa_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    stat_t            status;
  } grant_t;

  // mirrors the pool: bump pointer, min-heap of freed slots and the limit register
  class grant_scoreboard;
    int unsigned      pool_limit;
    int unsigned      bump_next;
    int unsigned      heap_count;
    logic [IDX_W-1:0] heap_slots[CAPACITY];
    grant_t           awaited_grants[$];
    int unsigned      error_count;

    function new();
      pool_limit  = CFG_RESET;
      bump_next   = 0;
      heap_count  = 0;
      error_count = 0;
    endfunction

    function void write_limit(logic [CFG_W-1:0] value);
      pool_limit = value;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [IDX_W-1:0] t;
      t = heap_slots[a];
      heap_slots[a] = heap_slots[b];
      heap_slots[b] = t;
    endfunction

    function void sift_up(int unsigned pos);
      int unsigned up;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (heap_slots[pos] >= heap_slots[up]) break;
        swap_slots(pos, up);
        pos = up;
      end
    endfunction

    function void sift_down();
      int unsigned pos;
      int unsigned l;
      int unsigned m;
      pos = 0;
      forever begin
        l = 2 * pos + 1;
        m = pos;
        if (l < heap_count && heap_slots[l] < heap_slots[m]) m = l;
        if (l + 1 < heap_count && heap_slots[l + 1] < heap_slots[m]) m = l + 1;
        if (m == pos) break;
        swap_slots(pos, m);
        pos = m;
      end
    endfunction

    function void note_request(input logic op, input logic [IDX_W-1:0] idx,
                               output logic [IDX_W-1:0] granted, output stat_t status);
      int unsigned limit;
      int unsigned slot;
      slot    = idx;
      granted = '0;
      status  = STAT_DONE;
      if (op == OP_ALLOC) begin
        limit = (pool_limit < CAPACITY) ? pool_limit : CAPACITY;
        if (heap_count > 0) begin
          granted = heap_slots[0];
          heap_count--;
          heap_slots[0] = heap_slots[heap_count];
          sift_down();
        end else if (bump_next < limit) begin
          granted = IDX_W'(bump_next);
          bump_next++;
        end else begin
          status = STAT_FULL;
        end
      end else begin
        if (slot >= bump_next) begin
          status = STAT_BAD;
        end else if (slot + 1 == bump_next) begin
          bump_next--;
        end else if (heap_count >= CAPACITY) begin
          status = STAT_BAD;
        end else begin
          heap_slots[heap_count] = idx;
          heap_count++;
          sift_up(heap_count - 1);
        end
      end
      awaited_grants.push_back('{granted: granted, status: status});
    endfunction

    function void check_grant(logic [IDX_W-1:0] granted, logic [STAT_W-1:0] status);
      grant_t want;
      if (awaited_grants.size() == 0) begin
        $display("%0t: result with nothing awaited: granted_index %0d status %0d",
                 $time, granted, status);
        error_count++;
        return;
      end
      want = awaited_grants.pop_front();
      if (granted !== want.granted) begin
        $display("%0t: granted_index mismatch: expected %0d actual %0d",
                 $time, want.granted, granted);
        error_count++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, status);
        error_count++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [CFG_W-1:0]   cfg_data;
  logic               req_valid;
  logic               req_stall;
  logic               operation;
  logic [IDX_W-1:0]   free_index;
  logic               rsp_valid;
  logic               rsp_stall;
  logic [IDX_W-1:0]   granted_index;
  logic [STAT_W-1:0]  status;

  grant_scoreboard    sb = new();
  logic [IDX_W-1:0]   held[$];
  int                 send_idle_pct;
  int                 recv_idle_pct;
  bit                 hold_wanted;

  lowest_first_slot_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .operation     (operation),
    .free_index    (free_index),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .granted_index (granted_index),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when asked for
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) sb.check_grant(granted_index, status);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left   = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] granted;
    stat_t            result;
    int               hits[$];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    operation  <= op;
    free_index <= idx;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(op, idx, granted, result);
    if (result == STAT_DONE) begin
      if (op == OP_ALLOC) begin
        held.push_back(granted);
      end else begin
        hits = held.find_first_index(x) with (x == idx);
        if (hits.size() != 0) held.delete(hits[0]);
      end
    end
  endtask

  task automatic send_alloc();
    send_item(OP_ALLOC, IDX_W'($urandom_range(0, CAPACITY - 1)));
  endtask

  // only once every result is back, so the block is idle
  task automatic write_limit(input logic [CFG_W-1:0] value);
    req_valid <= 1'b0;
    while (sb.awaited_grants.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_limit(value);
    cfg_write <= 1'b0;
  endtask

  task automatic random_item(input int alloc_pct);
    int kind;
    if ($urandom_range(0, 99) < alloc_pct) begin
      send_alloc();
    end else begin
      kind = $urandom_range(0, 9);
      if (kind == 0 || (kind > 1 && held.size() == 0)) begin
        // noise: bad index or double free
        send_item(OP_FREE, IDX_W'($urandom_range(0, CAPACITY - 1)));
      end else if (kind == 1 && sb.bump_next > 0) begin
        send_item(OP_FREE, IDX_W'(sb.bump_next - 1));
      end else if (held.size() != 0) begin
        send_item(OP_FREE, held[$urandom_range(0, held.size() - 1)]);
      end else begin
        send_alloc();
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] limit, input int items,
                           input int send_pct, input int recv_pct,
                           input int alloc_early, input int alloc_late, input bit hold);
    write_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < items; i++) begin
      if (hold && i == items / 2) hold_wanted = 1'b1;
      random_item((i < items / 2) ? alloc_early : alloc_late);
    end
  endtask

  initial begin
    hold_wanted   = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 47;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_data   <= '0;
    req_valid  <= 1'b0;
    operation  <= OP_ALLOC;
    free_index <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: bump, heap order, step back, bad frees, double free, limit changes
    repeat (5) send_alloc();
    send_item(OP_FREE, 11'd1);
    send_item(OP_FREE, 11'd3);
    send_item(OP_FREE, 11'd0);
    send_item(OP_FREE, 11'd4);
    send_item(OP_FREE, 11'd4);
    send_item(OP_FREE, 11'h7FF);
    repeat (4) send_item(OP_ALLOC, 11'h7FF);
    send_item(OP_FREE, 11'd1);
    send_item(OP_FREE, 11'd1);
    repeat (2) send_item(OP_ALLOC, 11'd0);
    write_limit(12'd2);
    send_alloc();
    send_item(OP_FREE, 11'd2);
    repeat (2) send_alloc();
    write_limit(12'd0);
    send_alloc();
    send_item(OP_FREE, 11'd4);

    run_phase(12'd37,   450, 16, 47, 55, 55, 1'b1);
    run_phase(12'd1,    150, 16, 47, 50, 50, 1'b0);
    run_phase(12'hFFF,  500, 47, 16, 75, 30, 1'b1);
    run_phase(12'd0,    100, 47, 16, 50, 50, 1'b0);
    run_phase(12'd2048, 550,  0,  0, 70, 35, 1'b0);

    req_valid <= 1'b0;
    while (sb.awaited_grants.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.error_count == 0 && sb.awaited_grants.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
